// ----- hw/rtl/scs_pkg.sv -----
package scs_pkg;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        segment_last;
    logic        message_last;
    logic [31:0] expected_checksum;
  } item_t;

  typedef struct packed {
    logic [31:0] checksum;
    logic [31:0] payload_length;
    logic        checksum_match;
  } result_t;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/segmented_crc32_xor_checksum_core.sv -----
// Per-segment reflected CRC-32 (poly 0xEDB88320, init all ones, final invert),
// XORed across the segments of a message, plus a saturating payload byte count.
// One input beat per clock sustained while in_ready is high. An input beat
// is staged in an input register and folded into the running state as it
// leaves that register; a message-end beat lands its result in the output
// register at that same edge. in_ready drops only when the staged beat ends
// a message while the output register still holds a result not yet taken.
module segmented_crc32_xor_checksum_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_segment_last,
  input  logic        in_message_last,
  input  logic [31:0] in_expected_checksum,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_checksum,
  output logic [31:0] out_payload_length,
  output logic        out_checksum_match
);

  logic             stg_valid_r, stg_valid_nxt;
  scs_pkg::item_t   stg_item_r;
  logic             out_valid_r, out_valid_nxt;
  scs_pkg::result_t out_res_r;
  scs_pkg::result_t res;
  logic             out_free;
  logic             fire;
  logic             in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = stg_valid_r && (!stg_item_r.message_last || out_free);
  assign in_ready = !stg_valid_r || fire;
  assign in_fire  = in_valid && in_ready;

  scs_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (stg_item_r),
    .result (res)
  );

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_fire) begin
      stg_valid_nxt = 1'b1;
    end else if (fire) begin
      stg_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire && stg_item_r.message_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_item_r.data_byte         <= in_data_byte;
      stg_item_r.byte_present      <= in_byte_present;
      stg_item_r.segment_last      <= in_segment_last;
      stg_item_r.message_last      <= in_message_last;
      stg_item_r.expected_checksum <= in_expected_checksum;
    end
    if (fire && stg_item_r.message_last) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_checksum       = out_res_r.checksum;
  assign out_payload_length = out_res_r.payload_length;
  assign out_checksum_match = out_res_r.checksum_match;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !fire |-> stg_item_r.message_last && out_valid_r && !out_ready)
    else $error("staged beat stalled without a blocked result");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stg_item_r.message_last |=> out_valid_r)
    else $error("message end did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(out_res_r))
    else $error("pending result overwritten");

endmodule

// ----- hw/rtl/scs_accum.sv -----
module scs_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  scs_pkg::item_t   item,
  output scs_pkg::result_t result
);

  logic [31:0] segment_crc_r, segment_crc_nxt;
  logic [31:0] message_xor_r, message_xor_nxt;
  logic [31:0] byte_count_r,  byte_count_nxt;
  logic [31:0] crc_abs;
  logic [31:0] cnt_abs;
  logic [31:0] xor_closed;
  logic        seg_close;

  assign seg_close = item.segment_last | item.message_last;

  always_comb begin
    crc_abs = segment_crc_r;
    cnt_abs = byte_count_r;
    if (item.byte_present) begin
      crc_abs = scs_pkg::crc_byte(segment_crc_r, item.data_byte);
      if (byte_count_r != scs_pkg::CNT_MAX) begin
        cnt_abs = byte_count_r + 32'd1;
      end
    end
    // closing a segment folds in its finalized CRC (empty segment gives zero)
    xor_closed = seg_close ? (message_xor_r ^ crc_abs ^ scs_pkg::CRC_INIT)
                           : message_xor_r;
  end

  always_comb begin
    segment_crc_nxt = segment_crc_r;
    message_xor_nxt = message_xor_r;
    byte_count_nxt  = byte_count_r;
    if (fire) begin
      if (item.message_last) begin
        segment_crc_nxt = scs_pkg::CRC_INIT;
        message_xor_nxt = 32'd0;
        byte_count_nxt  = 32'd0;
      end else begin
        segment_crc_nxt = seg_close ? scs_pkg::CRC_INIT : crc_abs;
        message_xor_nxt = xor_closed;
        byte_count_nxt  = cnt_abs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_crc_r <= scs_pkg::CRC_INIT;
      message_xor_r <= 32'd0;
      byte_count_r  <= 32'd0;
    end else begin
      segment_crc_r <= segment_crc_nxt;
      message_xor_r <= message_xor_nxt;
      byte_count_r  <= byte_count_nxt;
    end
  end

  assign result.checksum       = xor_closed;
  assign result.payload_length = cnt_abs;
  assign result.checksum_match = (xor_closed == item.expected_checksum);

  a_msg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.message_last |=>
      segment_crc_r == scs_pkg::CRC_INIT && message_xor_r == 32'd0 &&
      byte_count_r == 32'd0)
    else $error("state not cleared after message end");

  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.message_last |=> byte_count_r >= $past(byte_count_r))
    else $error("byte count went backward inside a message");

  a_marker_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.byte_present && !item.segment_last && !item.message_last |=>
      $stable(segment_crc_r) && $stable(message_xor_r) && $stable(byte_count_r))
    else $error("marker-only beat changed state");

endmodule
